// ===== hdl/sspc_pkg.sv =====
// shared types and constants of the sorted source packet counter
package sspc_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int ADDR_W  = 32;
	localparam int IFACE_W = 8;
	localparam int COUNT_W = 32;
	localparam int INDEX_W = 8;
	localparam int OCC_W   = 9;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_COUNT  = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STAT_COUNTED   = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_APPENDED  = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_READ_OK   = 3'd4,
		STAT_BAD_INDEX = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_EXEC
	} fsm_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INC,
		OP_LOAD,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [IFACE_W-1:0] iface;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic hit;   // valid entry with same address and interface
		logic gt;    // valid entry with a greater address
		logic tail;  // first free position
		logic rsel;  // valid entry at the requested read index
	} cell_flags_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		sat_inc = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
	endfunction

endpackage

// ===== hdl/sorted_source_packet_counter_unit.sv =====
// top level of the sorted source packet counter: control, cell row and result register
//
// Keeps up to TABLE_DEPTH (address, interface, count) entries in a row of cells,
// in ascending address order. A count beat bumps the first matching entry
// (saturating) or inserts a new entry with count 1 after all entries of lower
// or equal address; an append beat stores a saved entry at the end; a read
// beat returns the entry at read_index. Every beat gives exactly one result.
// In the compare state the held beat is broadcast to every cell and each cell
// registers its own compare flags; in the execute state two parallel prefix
// ors over the flag row pick the first match and the insert point, the cells
// increment, load or shift one place right all at once, and the result
// register is loaded. The next beat is taken during the execute state when
// the result register is free, so a beat can be accepted while the last one
// finishes; a stalled result holds the block in the execute state. Entries
// need no clearing after reset: only positions below the fill count are used.
module sorted_source_packet_counter_unit #(
	parameter int TABLE_DEPTH = sspc_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beats
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [sspc_pkg::ADDR_W-1:0]   src_addr,
	input  logic [sspc_pkg::IFACE_W-1:0]  iface_id,
	input  logic [sspc_pkg::COUNT_W-1:0]  load_count,
	input  logic [sspc_pkg::INDEX_W-1:0]  read_index,
	// result beats
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [sspc_pkg::ADDR_W-1:0]   out_addr,
	output logic [sspc_pkg::IFACE_W-1:0]  out_iface_id,
	output logic [sspc_pkg::COUNT_W-1:0]  out_count,
	output logic [sspc_pkg::OCC_W-1:0]    occupancy
);
	import sspc_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// control
	fsm_t state_q, state_nxt;
	logic out_free, advance, accept, cmp_en;

	// held beat
	logic [1:0]         kind_q;
	entry_t             item_q;
	logic [COUNT_W-1:0] lcount_q;
	logic [INDEX_W-1:0] ridx_q;

	// fill count
	logic [CW-1:0] used_q, used_nxt;

	// result register
	logic               out_valid_q;
	status_t            out_status_q, res_status;
	entry_t             out_entry_q, res_entry;
	logic [OCC_W-1:0]   out_occ_q;

	// cell row
	entry_t           ent_w  [TABLE_DEPTH];
	cell_flags_t      flg_w  [TABLE_DEPTH];
	cell_op_t         op_w   [TABLE_DEPTH];
	entry_t           new_entry;
	logic [TABLE_DEPTH-1:0] hit_v, gt_v, tail_v, rsel_v;
	logic [TABLE_DEPTH-1:0] hit_pre, gt_pre, hit_before, gt_before, first_hit;
	logic any_hit, any_gt, any_rsel, full;
	entry_t sel_entry;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = state_q == FSM_EXEC && out_free;
	assign in_stall = !(state_q == FSM_IDLE || advance);
	assign accept   = in_valid && !in_stall;
	assign cmp_en   = state_q == FSM_CMP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: if (accept) state_nxt = FSM_CMP;
			FSM_CMP:  state_nxt = FSM_EXEC;
			FSM_EXEC: begin
				if (advance) state_nxt = accept ? FSM_CMP : FSM_IDLE;
			end
			default:  state_nxt = FSM_IDLE;
		endcase
	end

	// beat holding register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= kind;
			item_q.addr  <= src_addr;
			item_q.iface <= iface_id;
			item_q.count <= '0;
			lcount_q     <= load_count;
			ridx_q       <= read_index;
		end
	end

	// cells
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		entry_t prev;
		if (g == 0) begin : g_first
			assign prev = '0;
		end else begin : g_rest
			assign prev = ent_w[g-1];
		end

		sspc_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.CELL_IDX   (g)
		) u_cell (
			.clk       (clk),
			.cmp_en    (cmp_en),
			.probe     (item_q),
			.read_index(ridx_q),
			.used      (used_q),
			.op        (op_w[g]),
			.new_entry (new_entry),
			.prev_entry(prev),
			.entry     (ent_w[g]),
			.flags     (flg_w[g])
		);

		assign hit_v[g]  = flg_w[g].hit;
		assign gt_v[g]   = flg_w[g].gt;
		assign tail_v[g] = flg_w[g].tail;
		assign rsel_v[g] = flg_w[g].rsel;
	end

	sspc_prefix_or #(.WIDTH(TABLE_DEPTH)) u_hit_pre (.d(hit_v), .p(hit_pre));
	sspc_prefix_or #(.WIDTH(TABLE_DEPTH)) u_gt_pre  (.d(gt_v),  .p(gt_pre));

	// exclusive prefixes: something earlier in the row already matched
	assign hit_before = {hit_pre[TABLE_DEPTH-2:0], 1'b0};
	assign gt_before  = {gt_pre[TABLE_DEPTH-2:0], 1'b0};
	assign first_hit  = hit_v & ~hit_before;
	assign any_hit    = hit_pre[TABLE_DEPTH-1];
	assign any_gt     = gt_pre[TABLE_DEPTH-1];
	assign any_rsel   = |rsel_v;
	assign full       = used_q == CW'(TABLE_DEPTH);

	// entry a new position is loaded with
	always_comb begin
		new_entry       = item_q;
		new_entry.count = (kind_q == KIND_APPEND) ? lcount_q : COUNT_W'(1);
	end

	// per cell action, only when the result can be taken
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			op_w[i] = OP_HOLD;
			if (advance) begin
				case (kind_q)
					KIND_APPEND: begin
						if (!full && tail_v[i]) op_w[i] = OP_LOAD;
					end
					KIND_COUNT: begin
						if (any_hit) begin
							if (first_hit[i]) op_w[i] = OP_INC;
						end else if (!full) begin
							// insert before the first greater address, else at the tail
							if (gt_before[i])
								op_w[i] = OP_SHIFT;
							else if (gt_v[i] || (!any_gt && tail_v[i]))
								op_w[i] = OP_LOAD;
						end
					end
					default: op_w[i] = OP_HOLD;
				endcase
			end
		end
	end

	// one-hot select of the matched or read entry
	always_comb begin
		sel_entry = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (kind_q == KIND_COUNT ? first_hit[i] : rsel_v[i])
				sel_entry = sel_entry | ent_w[i];
		end
	end

	// result and new fill count
	always_comb begin
		res_status = STAT_BAD_INDEX;
		res_entry  = '0;
		used_nxt   = used_q;
		case (kind_q)
			KIND_APPEND: begin
				res_entry = item_q;
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					res_status      = STAT_APPENDED;
					res_entry.count = lcount_q;
					used_nxt        = used_q + CW'(1);
				end
			end
			KIND_COUNT: begin
				res_entry = item_q;
				if (any_hit) begin
					res_status      = STAT_COUNTED;
					res_entry.count = sat_inc(sel_entry.count);
				end else if (full) begin
					res_status = STAT_FULL;
				end else begin
					res_status      = STAT_INSERTED;
					res_entry.count = COUNT_W'(1);
					used_nxt        = used_q + CW'(1);
				end
			end
			KIND_READ: begin
				if (any_rsel) begin
					res_status = STAT_READ_OK;
					res_entry  = sel_entry;
				end
			end
			default: res_status = STAT_BAD_INDEX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				used_q      <= used_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= res_status;
			out_entry_q  <= res_entry;
			out_occ_q    <= OCC_W'(used_nxt);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_addr     = out_entry_q.addr;
	assign out_iface_id = out_entry_q.iface;
	assign out_count    = out_entry_q.count;
	assign occupancy    = out_occ_q;

endmodule

// ===== hdl/sspc_prefix_or.sv =====
// parallel prefix or over a row of cell flags
module sspc_prefix_or #(
	parameter int WIDTH = sspc_pkg::TABLE_DEPTH_DEF
) (
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] p
);
	import sspc_pkg::*;

	localparam int LEVELS = $clog2(WIDTH);

	logic [WIDTH-1:0] lvl [LEVELS+1];

	assign lvl[0] = d;

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		for (genvar i = 0; i < WIDTH; i++) begin : g_bit
			if (i >= (1 << k)) begin : g_or
				assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
			end else begin : g_pass
				assign lvl[k+1][i] = lvl[k][i];
			end
		end
	end

	assign p = lvl[LEVELS];

endmodule

// ===== hdl/sspc_cell.sv =====
// one table position: stored entry, compare flags and shift from the left neighbour
module sspc_cell #(
	parameter int TABLE_DEPTH = sspc_pkg::TABLE_DEPTH_DEF,
	parameter int CELL_IDX    = 0
) (
	input  logic                                 clk,
	input  logic                                 cmp_en,
	input  sspc_pkg::entry_t                     probe,
	input  logic [sspc_pkg::INDEX_W-1:0]         read_index,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]     used,
	input  sspc_pkg::cell_op_t                   op,
	input  sspc_pkg::entry_t                     new_entry,
	input  sspc_pkg::entry_t                     prev_entry,
	output sspc_pkg::entry_t                     entry,
	output sspc_pkg::cell_flags_t                flags
);
	import sspc_pkg::*;

	entry_t      entry_q;
	cell_flags_t flags_q;
	logic        valid;

	assign valid = 32'(CELL_IDX) < 32'(used);

	// compare against the broadcast beat
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			flags_q.hit  <= valid && entry_q.addr == probe.addr
				&& entry_q.iface == probe.iface;
			flags_q.gt   <= valid && entry_q.addr > probe.addr;
			flags_q.tail <= 32'(CELL_IDX) == 32'(used);
			flags_q.rsel <= valid && 32'(CELL_IDX) == 32'(read_index);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_INC:   entry_q.count <= sat_inc(entry_q.count);
			OP_LOAD:  entry_q       <= new_entry;
			OP_SHIFT: entry_q       <= prev_entry;
			default:  entry_q       <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign flags = flags_q;

endmodule

// ===== hdl/sspc_checker.sv =====
// port level checks of the sorted source packet counter, bound to the top level
module sspc_checker #(
	parameter int TABLE_DEPTH = sspc_pkg::TABLE_DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    status,
	input logic [sspc_pkg::ADDR_W-1:0]   out_addr,
	input logic [sspc_pkg::IFACE_W-1:0]  out_iface_id,
	input logic [sspc_pkg::COUNT_W-1:0]  out_count,
	input logic [sspc_pkg::OCC_W-1:0]    occupancy
);
	import sspc_pkg::*;

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_addr)
			&& $stable(out_iface_id) && $stable(out_count) && $stable(occupancy))
		else $error("stalled result beat changed");

	// one beat at a time: the cycle after a beat is taken the input is stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("beat taken while previous one still in compare");

	// fill count never passes the table size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> TABLE_DEPTH > 511 || 32'(occupancy) <= 32'(TABLE_DEPTH))
		else $error("occupancy above table size");

	// an inserted entry starts at one
	a_insert_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_INSERTED |-> out_count == 32'd1)
		else $error("inserted entry count not one");

	// a refused read reports zeros
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_BAD_INDEX |->
			out_addr == '0 && out_iface_id == '0 && out_count == '0)
		else $error("bad index result not zero");

endmodule

bind sorted_source_packet_counter_unit sspc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sspc_checker (.*);
